>>> hw/rtl/bspu_pkg.sv
// Package: shared types, constants and helpers for the Burgers stencil point update.
package bspu_pkg;

  localparam int QW = 48;
  localparam int TW = 47;
  localparam int IW = 10;
  localparam int GRID_COLS = 1024;
  localparam int GRID_ROWS = 1024;
  localparam int BW = $clog2(GRID_COLS > GRID_ROWS ? GRID_COLS : GRID_ROWS);
  localparam int CFG_AW = 3;
  localparam logic [QW-1:0] ACTIVE_LSB = 48'd42;
  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

  typedef enum logic [CFG_AW-1:0] {
    REG_WEST   = 3'd0,
    REG_EAST   = 3'd1,
    REG_CENTER = 3'd2,
    REG_NORTH  = 3'd3,
    REG_SOUTH  = 3'd4,
    REG_ADX    = 3'd5,
    REG_ADY    = 3'd6,
    REG_DT     = 3'd7
  } reg_idx_t;

  // Operand selects of the shared multiplier.
  typedef enum logic [1:0] {
    A_COEF = 2'd0,
    A_UC   = 2'd1,
    A_VC   = 2'd2,
    A_DT   = 2'd3
  } asel_t;

  typedef enum logic [2:0] {
    B_W    = 3'd0,
    B_DX   = 3'd1,
    B_DY   = 3'd2,
    B_PROD = 3'd3,
    B_SUM  = 3'd4
  } bsel_t;

  typedef enum logic [1:0] {
    ACC_NONE = 2'd0,
    ACC_ADD  = 2'd1,
    ACC_SUB  = 2'd2
  } accop_t;

  typedef struct packed {
    logic       load;       // capture input item
    logic       comp;       // 0 = u, 1 = v
    asel_t      asel;
    logic [2:0] coef;       // coefficient register index
    bsel_t      bsel;
    logic [2:0] wsel;       // stencil tap: c,w,e,n,s
    logic       mul_go;     // register product
    accop_t     accop;
    logic       acc_clr;
    logic       store;      // store product as final value of comp
    logic       finish;     // update box, fill output
  } dp_cmd_t;

  typedef struct packed {
    logic dummy;
  } dp_sts_t;

  function automatic logic signed [QW-1:0] sat_q(input logic signed [QW+3:0] x);
    if (x > $signed({{4{1'b0}}, Q_MAX})) return Q_MAX;
    if (x < $signed({{4{1'b1}}, Q_MIN})) return Q_MIN;
    return x[QW-1:0];
  endfunction

endpackage

>>> hw/rtl/bspu_if.sv
// Interfaces: input and result channels.
interface bspu_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [bspu_pkg::IW-1:0] row;
  logic [bspu_pkg::IW-1:0] col;
  logic signed [bspu_pkg::QW-1:0] u_center, u_west, u_east, u_north, u_south;
  logic signed [bspu_pkg::QW-1:0] v_center, v_west, v_east, v_north, v_south;
  modport source (output valid, row, col, u_center, u_west, u_east, u_north, u_south,
                  v_center, v_west, v_east, v_north, v_south, input ready);
  modport sink (input valid, row, col, u_center, u_west, u_east, u_north, u_south,
                v_center, v_west, v_east, v_north, v_south, output ready);
endinterface

interface bspu_out_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [bspu_pkg::QW-1:0] new_u, new_v;
  logic active;
  logic [bspu_pkg::IW-1:0] left_bound, right_bound, top_bound, bottom_bound;
  modport source (output valid, new_u, new_v, active, left_bound, right_bound,
                  top_bound, bottom_bound, input ready);
  modport sink (input valid, new_u, new_v, active, left_bound, right_bound,
                top_bound, bottom_bound, output ready);
endinterface

>>> hw/rtl/bspu_mul.sv
// Registered Q16.32 multiplier: rounded, saturated; partial products split at bit 32.
module bspu_mul (
  input  logic                          clk,
  input  logic                          go,
  input  logic signed [bspu_pkg::QW-1:0] a,
  input  logic signed [bspu_pkg::QW-1:0] b,
  output logic signed [bspu_pkg::QW-1:0] p
);
  logic [bspu_pkg::QW-1:0] ma, mb;
  logic neg;
  logic [63:0] hh_nxt, hl_nxt, lh_nxt, ll_nxt;
  logic [63:0] hh_r, hl_r, lh_r, ll_r;
  logic neg_r;
  logic [65:0] q;

  assign neg = a[bspu_pkg::QW-1] ^ b[bspu_pkg::QW-1];
  assign ma  = a[bspu_pkg::QW-1] ? -a : a;
  assign mb  = b[bspu_pkg::QW-1] ? -b : b;
  assign hh_nxt = {48'd0, ma[47:32]} * {48'd0, mb[47:32]};
  assign hl_nxt = {48'd0, ma[47:32]} * {32'd0, mb[31:0]};
  assign lh_nxt = {32'd0, ma[31:0]} * {48'd0, mb[47:32]};
  assign ll_nxt = {32'd0, ma[31:0]} * {32'd0, mb[31:0]};

  always_ff @(posedge clk) begin
    if (go) begin
      hh_r  <= hh_nxt;
      hl_r  <= hl_nxt;
      lh_r  <= lh_nxt;
      ll_r  <= ll_nxt;
      neg_r <= neg;
    end
  end

  always_comb begin
    q = {hh_r[33:0], 32'd0} + {2'd0, hl_r} + {2'd0, lh_r}
      + {34'd0, ll_r[63:32]} + {65'd0, ll_r[31]};
    if (neg_r) begin
      if (q >= 66'h800000000000) p = bspu_pkg::Q_MIN;
      else p = -q[47:0];
    end else begin
      if (q > 66'h7FFFFFFFFFFF) p = bspu_pkg::Q_MAX;
      else p = q[47:0];
    end
  end
endmodule

>>> hw/rtl/bspu_datapath.sv
// Datapath: config registers, item capture, shared multiplier, accumulator and box.
module bspu_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [bspu_pkg::CFG_AW-1:0] cfg_index,
  input  logic [bspu_pkg::QW-1:0] cfg_data,
  input  bspu_pkg::dp_cmd_t     cmd,
  output bspu_pkg::dp_sts_t     sts,
  bspu_in_if.sink               in_ch,
  output logic signed [bspu_pkg::QW-1:0] new_u,
  output logic signed [bspu_pkg::QW-1:0] new_v,
  output logic                  active,
  output logic [bspu_pkg::IW-1:0] left_bound,
  output logic [bspu_pkg::IW-1:0] right_bound,
  output logic [bspu_pkg::IW-1:0] top_bound,
  output logic [bspu_pkg::IW-1:0] bottom_bound
);
  localparam int QW = bspu_pkg::QW;
  localparam int BW = bspu_pkg::BW;

  logic signed [QW-1:0] coef_r [7];
  logic [bspu_pkg::TW-1:0] dt_r;
  logic [bspu_pkg::IW-1:0] row_r, col_r;
  logic signed [QW-1:0] w_r [2][5];
  logic signed [QW-1:0] dx_r [2], dy_r [2];
  logic signed [QW+3:0] acc_r;
  logic signed [QW-1:0] res_r [2];
  logic [BW-1:0] bl_r, br_r, bt_r, bb_r;
  logic signed [QW-1:0] a, b, p;
  logic signed [QW:0] dx_full, dy_full;
  logic [QW-1:0] mu, mv;
  logic act;

  assign sts.dummy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 7; i++) coef_r[i] <= '0;
      dt_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == bspu_pkg::REG_DT) dt_r <= cfg_data[bspu_pkg::TW-1:0];
      else coef_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_r <= in_ch.row;
      col_r <= in_ch.col;
      w_r[0][0] <= in_ch.u_center; w_r[0][1] <= in_ch.u_west;
      w_r[0][2] <= in_ch.u_east;   w_r[0][3] <= in_ch.u_north;
      w_r[0][4] <= in_ch.u_south;
      w_r[1][0] <= in_ch.v_center; w_r[1][1] <= in_ch.v_west;
      w_r[1][2] <= in_ch.v_east;   w_r[1][3] <= in_ch.v_north;
      w_r[1][4] <= in_ch.v_south;
      for (int c = 0; c < 2; c++) begin
        dx_r[c] <= '0;
        dy_r[c] <= '0;
      end
    end else begin
      for (int c = 0; c < 2; c++) begin
        dx_r[c] <= bspu_pkg::sat_q({{3{dx_full[QW]}}, dx_full});
        dy_r[c] <= bspu_pkg::sat_q({{3{dy_full[QW]}}, dy_full});
      end
    end
  end

  // Differences for the component under work; both slots track the same value.
  assign dx_full = {w_r[cmd.comp][0][QW-1], w_r[cmd.comp][0]}
                 - {w_r[cmd.comp][1][QW-1], w_r[cmd.comp][1]};
  assign dy_full = {w_r[cmd.comp][0][QW-1], w_r[cmd.comp][0]}
                 - {w_r[cmd.comp][3][QW-1], w_r[cmd.comp][3]};

  always_comb begin
    case (cmd.asel)
      bspu_pkg::A_COEF: a = coef_r[cmd.coef];
      bspu_pkg::A_UC:   a = w_r[0][0];
      bspu_pkg::A_VC:   a = w_r[1][0];
      bspu_pkg::A_DT:   a = {1'b0, dt_r};
      default:          a = '0;
    endcase
    case (cmd.bsel)
      bspu_pkg::B_W:    b = w_r[cmd.comp][cmd.wsel];
      bspu_pkg::B_DX:   b = dx_r[0];
      bspu_pkg::B_DY:   b = dy_r[0];
      bspu_pkg::B_PROD: b = p;
      bspu_pkg::B_SUM:  b = bspu_pkg::sat_q(acc_r);
      default:          b = '0;
    endcase
  end

  bspu_mul u_mul (.clk(clk), .go(cmd.mul_go), .a(a), .b(b), .p(p));

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) acc_r <= '0;
    else begin
      case (cmd.accop)
        bspu_pkg::ACC_ADD: acc_r <= acc_r + {{4{p[QW-1]}}, p};
        bspu_pkg::ACC_SUB: acc_r <= acc_r - {{4{p[QW-1]}}, p};
        default: ;
      endcase
    end
    if (cmd.store) res_r[cmd.comp] <= p;
  end

  assign mu  = res_r[0][QW-1] ? -res_r[0] : res_r[0];
  assign mv  = res_r[1][QW-1] ? -res_r[1] : res_r[1];
  assign act = (mu > bspu_pkg::ACTIVE_LSB) || (mv > bspu_pkg::ACTIVE_LSB);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bl_r <= BW'(bspu_pkg::GRID_COLS - 1);
      br_r <= '0;
      bt_r <= BW'(bspu_pkg::GRID_ROWS - 1);
      bb_r <= '0;
    end else if (cmd.finish && act) begin
      if (BW'(col_r) > BW'(1) && BW'(col_r) < BW'(bspu_pkg::GRID_COLS - 2)) begin
        if (bl_r >= BW'(col_r)) bl_r <= BW'(col_r) - BW'(1);
        if (br_r <= BW'(col_r)) br_r <= BW'(col_r) + BW'(1);
      end
      if (BW'(row_r) > BW'(1) && BW'(row_r) < BW'(bspu_pkg::GRID_ROWS - 2)) begin
        if (bt_r >= BW'(row_r)) bt_r <= BW'(row_r) - BW'(1);
        if (bb_r <= BW'(row_r)) bb_r <= BW'(row_r) + BW'(1);
      end
    end
  end

  assign new_u = res_r[0];
  assign new_v = res_r[1];
  assign active = act;
  assign left_bound   = bl_r[bspu_pkg::IW-1:0];
  assign right_bound  = br_r[bspu_pkg::IW-1:0];
  assign top_bound    = bt_r[bspu_pkg::IW-1:0];
  assign bottom_bound = bb_r[bspu_pkg::IW-1:0];
endmodule

>>> hw/rtl/bspu_ctrl.sv
// Controller: sequences the shared multiplier over the terms of u and v.
module bspu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bspu_pkg::dp_cmd_t cmd,
  input  bspu_pkg::dp_sts_t sts
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_FIN  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  // Steps per component: clear, 5 taps, prod uc*dx, adx*prod, vc*dy, ady*prod,
  // dt*sum, plus drain cycles between dependent products.
  localparam int NSTEP = 16;
  localparam int SW = $clog2(NSTEP);

  state_t state_r, state_nxt;
  logic [SW-1:0] step_r;
  logic comp_r;
  logic last;

  assign last = (step_r == SW'(NSTEP - 1));

  always_comb begin
    cmd = '0;
    cmd.comp = comp_r;
    in_ready = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);
    cmd.load = in_valid && in_ready;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_RUN;
      S_RUN: begin
        // Each product lands in the multiplier's registers; a later step accumulates, reuses or stores it.
        case (step_r)
          4'd0: cmd.acc_clr = 1'b1;
          4'd1, 4'd2, 4'd3, 4'd4, 4'd5: begin
            cmd.asel = bspu_pkg::A_COEF; cmd.bsel = bspu_pkg::B_W; cmd.mul_go = 1'b1;
            case (step_r)
              4'd1: begin cmd.coef = bspu_pkg::REG_WEST;   cmd.wsel = 3'd1; end
              4'd2: begin cmd.coef = bspu_pkg::REG_EAST;   cmd.wsel = 3'd2; end
              4'd3: begin cmd.coef = bspu_pkg::REG_CENTER; cmd.wsel = 3'd0; end
              4'd4: begin cmd.coef = bspu_pkg::REG_NORTH;  cmd.wsel = 3'd3; end
              default: begin cmd.coef = bspu_pkg::REG_SOUTH; cmd.wsel = 3'd4; end
            endcase
          end
          4'd6: begin cmd.asel = bspu_pkg::A_UC; cmd.bsel = bspu_pkg::B_DX; cmd.mul_go = 1'b1; end
          4'd8: begin
            cmd.asel = bspu_pkg::A_COEF; cmd.coef = bspu_pkg::REG_ADX;
            cmd.bsel = bspu_pkg::B_PROD; cmd.mul_go = 1'b1;
          end
          4'd9: begin cmd.asel = bspu_pkg::A_VC; cmd.bsel = bspu_pkg::B_DY; cmd.mul_go = 1'b1; end
          4'd11: begin
            cmd.asel = bspu_pkg::A_COEF; cmd.coef = bspu_pkg::REG_ADY;
            cmd.bsel = bspu_pkg::B_PROD; cmd.mul_go = 1'b1;
          end
          4'd14: begin cmd.asel = bspu_pkg::A_DT; cmd.bsel = bspu_pkg::B_SUM; cmd.mul_go = 1'b1; end
          default: ;
        endcase
        if (step_r >= 4'd2 && step_r <= 4'd6) cmd.accop = bspu_pkg::ACC_ADD;
        if (step_r == 4'd9 || step_r == 4'd12) cmd.accop = bspu_pkg::ACC_SUB;
        if (last) begin
          cmd.store = 1'b1;
          if (comp_r) state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      comp_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_RUN) begin
        step_r <= step_r + SW'(1);
        if (last) comp_r <= ~comp_r;
      end else begin
        step_r <= '0;
        comp_r <= 1'b0;
      end
    end
  end

  logic unused_sts;
  assign unused_sts = sts.dummy;
endmodule

>>> hw/rtl/burgers_stencil_point_update.sv
// Top level: explicit 2-D Burgers update of one grid point with active box tracking.
// After an input is accepted, the controller runs the steps for u, then for v, then a finish step before out_valid.
// Items are processed one at a time through the single shared multiplier.
// in_ready is high only when no item is in work; the result holds until taken.
// Reset (rst_n low, synchronous): config registers to zero, box to empty, controller idle.
// The box starts at left/top = grid size minus one, right/bottom = zero.
module burgers_stencil_point_update (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [bspu_pkg::CFG_AW-1:0] cfg_index,
  input  logic [bspu_pkg::QW-1:0] cfg_data,
  bspu_in_if.sink               in_ch,
  bspu_out_if.source            out_ch
);
  bspu_pkg::dp_cmd_t cmd;
  bspu_pkg::dp_sts_t sts;

  // Sequence the multiplier; hold the result until the sink takes it.
  bspu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .sts(sts)
  );

  bspu_datapath u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts), .in_ch(in_ch),
    .new_u(out_ch.new_u), .new_v(out_ch.new_v), .active(out_ch.active),
    .left_bound(out_ch.left_bound), .right_bound(out_ch.right_bound),
    .top_bound(out_ch.top_bound), .bottom_bound(out_ch.bottom_bound)
  );
endmodule

>>> hw/rtl/bspu_checker.sv
// Checker: port-level assertions bound to the top level.
module bspu_port_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("accepted two items");
endmodule

bind burgers_stencil_point_update bspu_port_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);

>>> tb/bspu_checker.sv
// Checker: predicts each result of the stencil point update and compares it with the block.
`timescale 1ns / 100ps

module bspu_checker
  import bspu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [QW-1:0]     cfg_data,
  bspu_in_if                in_mon,
  bspu_out_if               out_mon,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic signed [QW-1:0] new_u;
    logic signed [QW-1:0] new_v;
    logic                 active;
    logic [IW-1:0]        left_b;
    logic [IW-1:0]        right_b;
    logic [IW-1:0]        top_b;
    logic [IW-1:0]        bottom_b;
  } point_res_t;

  typedef logic signed [QW-1:0] q_t;

  q_t         coef [8];
  int         box_left, box_right, box_top, box_bottom;
  point_res_t expected_points [$];

  assign pending = expected_points.size();

  function automatic longint sat_wide(input longint x);
    if (x > longint'(Q_MAX)) return longint'(Q_MAX);
    if (x < longint'(Q_MIN)) return longint'(Q_MIN);
    return x;
  endfunction

  // Exact product, rounded to nearest with ties away from zero, then saturated.
  function automatic q_t fix_mul(input q_t a, input q_t b);
    logic signed [2*QW-1:0] p;
    logic [2*QW-1:0]        m;
    logic [2*QW-1:0]        q;
    p = $signed({{QW{a[QW-1]}}, a}) * $signed({{QW{b[QW-1]}}, b});
    m = p[2*QW-1] ? -p : p;
    q = (m + (96'd1 << 31)) >> 32;
    if (a[QW-1] != b[QW-1]) begin
      if (q >= (96'd1 << 47)) return Q_MIN;
      return -q[QW-1:0];
    end
    if (q > 96'(Q_MAX)) return Q_MAX;
    return q[QW-1:0];
  endfunction

  // Taps: center, west, east, north, south.
  function automatic q_t burgers_update(input q_t w [5], input q_t uc, input q_t vc);
    longint s;
    q_t     dx, dy;
    s = longint'(fix_mul(coef[REG_WEST], w[1])) + longint'(fix_mul(coef[REG_EAST], w[2]))
      + longint'(fix_mul(coef[REG_CENTER], w[0])) + longint'(fix_mul(coef[REG_NORTH], w[3]))
      + longint'(fix_mul(coef[REG_SOUTH], w[4]));
    dx = q_t'(sat_wide(longint'(w[0]) - longint'(w[1])));
    dy = q_t'(sat_wide(longint'(w[0]) - longint'(w[3])));
    s = s - longint'(fix_mul(coef[REG_ADX], fix_mul(uc, dx)));
    s = s - longint'(fix_mul(coef[REG_ADY], fix_mul(vc, dy)));
    return fix_mul(coef[REG_DT], q_t'(sat_wide(s)));
  endfunction

  function automatic bit above_threshold(input q_t x);
    longint m;
    m = longint'(x);
    if (m < 0) m = -m;
    return m > longint'(ACTIVE_LSB);
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    q_t         uw [5];
    q_t         vw [5];
    point_res_t r;
    point_res_t want;
    int         row, col;
    if (!rst_n) begin
      foreach (coef[i]) coef[i] = '0;
      box_left   = GRID_COLS - 1;
      box_right  = 0;
      box_top    = GRID_ROWS - 1;
      box_bottom = 0;
      expected_points.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_DT) coef[cfg_index] = {1'b0, cfg_data[TW-1:0]};
        else coef[cfg_index] = cfg_data;
      end
      // Compare first: a result taken at this edge belongs to an earlier item.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_points.size() == 0) begin
          $display("%0t unexpected result: expected none actual new_u %0d", $time,
                   out_mon.new_u);
          fail_count++;
        end else begin
          want = expected_points.pop_front();
          check_field("new_u", want.new_u, out_mon.new_u);
          check_field("new_v", want.new_v, out_mon.new_v);
          check_field("active", want.active, out_mon.active);
          check_field("left_bound", want.left_b, out_mon.left_bound);
          check_field("right_bound", want.right_b, out_mon.right_bound);
          check_field("top_bound", want.top_b, out_mon.top_bound);
          check_field("bottom_bound", want.bottom_b, out_mon.bottom_bound);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        uw = '{in_mon.u_center, in_mon.u_west, in_mon.u_east, in_mon.u_north, in_mon.u_south};
        vw = '{in_mon.v_center, in_mon.v_west, in_mon.v_east, in_mon.v_north, in_mon.v_south};
        row = in_mon.row;
        col = in_mon.col;
        r.new_u  = burgers_update(uw, uw[0], vw[0]);
        r.new_v  = burgers_update(vw, uw[0], vw[0]);
        r.active = above_threshold(r.new_u) || above_threshold(r.new_v);
        if (r.active) begin
          if (col > 1 && col < GRID_COLS - 2) begin
            if (box_left >= col) box_left = col - 1;
            if (box_right <= col) box_right = col + 1;
          end
          if (row > 1 && row < GRID_ROWS - 2) begin
            if (box_top >= row) box_top = row - 1;
            if (box_bottom <= row) box_bottom = row + 1;
          end
        end
        r.left_b   = box_left[IW-1:0];
        r.right_b  = box_right[IW-1:0];
        r.top_b    = box_top[IW-1:0];
        r.bottom_b = box_bottom[IW-1:0];
        expected_points.push_back(r);
      end
    end
  end

endmodule

>>> tb/burgers_stencil_point_update_test.sv
// Testbench top: drives stencil points and coefficient settings, and reports the verdict.
`timescale 1ns / 100ps

module burgers_stencil_point_update_test;
  import bspu_pkg::*;

  typedef logic signed [QW-1:0] q_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [QW-1:0]     cfg_data;
  int                fail_count;
  int                pending;

  // Idle rates in percent for the sender and the receiver.
  int send_idle;
  int recv_idle;
  // Request for a long receiver hold-off, served by the receiver process.
  bit hold_go;
  int hold_cnt;

  bspu_in_if  in_ch (clk);
  bspu_out_if out_ch (clk);

  burgers_stencil_point_update u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  bspu_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Receiver: take results at random, or hold off for a long stretch on request.
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go  = 1'b0;
      hold_cnt = 400;
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Sign-extended random value of the given width.
  function automatic q_t rnd_signed(input int bits);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    raw = raw << (64 - bits);
    return q_t'($signed(raw) >>> (64 - bits));
  endfunction

  // Stencil value: mostly moderate, some full range, extremes and values near zero.
  function automatic q_t rnd_value();
    case ($urandom_range(9))
      0:       return rnd_signed(QW);
      1:       return ($urandom_range(1)) ? Q_MAX : Q_MIN;
      2:       return q_t'($signed($urandom_range(200)) - 100);
      default: return rnd_signed($urandom_range(20, 36));
    endcase
  endfunction

  // Grid index: weight the edges and the cells next to them.
  function automatic logic [IW-1:0] rnd_index();
    case ($urandom_range(9))
      0:       return IW'($urandom_range(2));
      1:       return IW'(1021 + $urandom_range(2));
      default: return IW'($urandom_range(1023));
    endcase
  endfunction

  task automatic write_reg(input reg_idx_t idx, input q_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Load all eight registers in one of several styles.
  task automatic load_coefs(input int style);
    reg_idx_t idx;
    q_t       value;
    for (int i = 0; i < 8; i++) begin
      idx = reg_idx_t'(i);
      case (style)
        0:       value = rnd_signed(34);
        1:       value = Q_MAX;
        2:       value = Q_MIN;
        3:       value = rnd_signed(QW);
        default: value = rnd_signed(30);
      endcase
      // Time step: keep it small except for the extreme and fully random styles.
      if (idx == REG_DT && style != 1 && style != 2 && style != 3)
        value = q_t'($urandom_range(32'h4000_0000));
      if (idx == REG_DT && style == 2) value = Q_MAX;
      write_reg(idx, value);
    end
  endtask

  // Offer one point; hold it until the handshake, then maybe idle a little.
  task automatic send_point(input logic [IW-1:0] r, input logic [IW-1:0] c,
                            input q_t uw [5], input q_t vw [5]);
    bit took;
    in_ch.valid    <= 1'b1;
    in_ch.row      <= r;
    in_ch.col      <= c;
    in_ch.u_center <= uw[0];
    in_ch.u_west   <= uw[1];
    in_ch.u_east   <= uw[2];
    in_ch.u_north  <= uw[3];
    in_ch.u_south  <= uw[4];
    in_ch.v_center <= vw[0];
    in_ch.v_west   <= vw[1];
    in_ch.v_east   <= vw[2];
    in_ch.v_north  <= vw[3];
    in_ch.v_south  <= vw[4];
    // Sample ready mid-cycle, where it is settled for the coming edge.
    do begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end while (!took);
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_random_point();
    q_t uw [5];
    q_t vw [5];
    foreach (uw[i]) begin
      uw[i] = rnd_value();
      vw[i] = rnd_value();
    end
    send_point(rnd_index(), rnd_index(), uw, vw);
  endtask

  // Drop valid and wait until every result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    q_t uw [5];
    q_t vw [5];
    logic [IW-1:0] r, c;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.row    = '0;
    in_ch.col    = '0;
    {in_ch.u_center, in_ch.u_west, in_ch.u_east, in_ch.u_north, in_ch.u_south} = '0;
    {in_ch.v_center, in_ch.v_west, in_ch.v_east, in_ch.v_north, in_ch.v_south} = '0;
    send_idle    = 8;
    recv_idle    = 84;
    hold_go      = 1'b0;
    hold_cnt     = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: with reset coefficients every result is zero and the box stays empty.
    uw = '{Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX};
    send_point(10'd500, 10'd500, uw, uw);
    drain();

    // Directed: moderate coefficients, then the extremes.
    for (int style = 0; style < 3; style++) begin
      load_coefs(style);
      for (int d = 0; d < 8; d++) begin
        case (d)
          0: begin uw = '{default: '0}; vw = '{default: '0}; end
          1: begin uw = '{default: Q_MAX}; vw = '{default: Q_MAX}; end
          2: begin uw = '{default: Q_MIN}; vw = '{default: Q_MIN}; end
          3: begin uw = '{Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX}; vw = '{Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN}; end
          4: begin uw = '{default: q_t'(43)}; vw = '{default: q_t'(-42)}; end
          default: begin
            foreach (uw[i]) begin
              uw[i] = rnd_signed(34);
              vw[i] = rnd_signed(34);
            end
          end
        endcase
        // Walk the edges: 0, 1, 2 and 1021, 1022, 1023 on both axes.
        r = (d % 2) ? IW'(1021 + d % 3) : IW'(d % 3);
        c = (d % 2) ? IW'(d % 3) : IW'(1021 + d % 3);
        send_point(r, c, uw, vw);
      end
      drain();
    end

    // Random: 15 phases of 50 points, five coefficient styles per idling mode.
    for (int k = 0; k < 15; k++) begin
      case (k / 5)
        0:       begin send_idle = 8;  recv_idle = 84; end
        1:       begin send_idle = 84; recv_idle = 8;  end
        default: begin send_idle = 0;  recv_idle = 0;  end
      endcase
      load_coefs(k % 5);
      // Hold off the receiver while points keep coming, so the input stalls.
      if (k == 10) hold_go = 1'b1;
      repeat (50) send_random_point();
      drain();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/bspu_pkg.sv
hw/rtl/bspu_if.sv
hw/rtl/bspu_mul.sv
hw/rtl/bspu_datapath.sv
hw/rtl/bspu_ctrl.sv
hw/rtl/burgers_stencil_point_update.sv
hw/rtl/bspu_checker.sv
tb/bspu_checker.sv
tb/burgers_stencil_point_update_test.sv
